### sv/ffac_pkg.sv
`default_nettype none
package ffac_pkg;

  typedef enum logic [1:0] {
    EV_PLACED   = 2'd0,
    EV_QUEUED   = 2'd1,
    EV_FREED    = 2'd2,
    EV_REJECTED = 2'd3
  } ev_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_TICK  = 1'b1
  } opc_t;

  localparam logic [1:0] CFG_MEM_SIZE = 2'd0;
  localparam logic [1:0] CFG_OS_SIZE  = 2'd1;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  proc_id;
    logic [15:0] req_size;
    logic [15:0] time_value;
    logic [15:0] end_time;
  } in_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  out_proc;
    logic [15:0] base_addr;
    logic [15:0] seg_size;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        used;
    logic [7:0]  owner;
    logic [15:0] base;
    logic [15:0] len;
    logic [15:0] fin_time;
  } seg_ent_t;

  typedef enum logic [2:0] {
    SEG_NOP,
    SEG_WRITE,
    SEG_SPLIT,
    SEG_REMOVE,
    SEG_CLR_USED,
    SEG_SET_BASE
  } seg_op_t;

  typedef struct packed {
    seg_op_t     op;
    logic [15:0] size;
    seg_ent_t    wdata;
  } seg_cmd_t;

  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] len;
    logic [15:0] dur;
  } wq_ent_t;

  typedef enum logic [1:0] {
    WQ_NOP,
    WQ_WRITE,
    WQ_REMOVE
  } wq_op_t;

  typedef struct packed {
    wq_op_t  op;
    wq_ent_t wdata;
  } wq_cmd_t;

endpackage
`default_nettype wire

### sv/ffac_seg_cell.sv
`default_nettype none
module ffac_seg_cell #(
  parameter int POS = 0,
  parameter int IW  = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  input  ffac_pkg::seg_cmd_t cmd,
  input  wire [IW-1:0]       idx,
  input  ffac_pkg::seg_ent_t lo,
  input  ffac_pkg::seg_ent_t hi,
  output ffac_pkg::seg_ent_t ent
);

  ffac_pkg::seg_ent_t ent_r, ent_nxt;
  int p;

  assign p   = int'(idx);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      ffac_pkg::SEG_WRITE: begin
        if (POS == p) ent_nxt = cmd.wdata;
      end
      ffac_pkg::SEG_SPLIT: begin
        // cell f takes the request, f+1 the remainder of the hole, above shifts up
        if (POS == p) begin
          ent_nxt.used     = 1'b1;
          ent_nxt.owner    = cmd.wdata.owner;
          ent_nxt.fin_time = cmd.wdata.fin_time;
          ent_nxt.len      = cmd.size;
        end else if (POS == p + 1) begin
          ent_nxt.used     = 1'b0;
          ent_nxt.owner    = 8'd0;
          ent_nxt.fin_time = 16'd0;
          ent_nxt.base     = lo.base + cmd.size;
          ent_nxt.len      = lo.len - cmd.size;
        end else if (POS > p + 1) begin
          ent_nxt = lo;
        end
      end
      ffac_pkg::SEG_REMOVE: begin
        if (POS >= p) ent_nxt = hi;
      end
      ffac_pkg::SEG_CLR_USED: begin
        if (POS == p) ent_nxt.used = 1'b0;
      end
      ffac_pkg::SEG_SET_BASE: begin
        if (POS == p) ent_nxt.base = cmd.wdata.base;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ent_r.used <= 1'b0;
    else        ent_r      <= ent_nxt;
  end

endmodule
`default_nettype wire

### sv/ffac_wait_cell.sv
`default_nettype none
module ffac_wait_cell #(
  parameter int POS = 0,
  parameter int IW  = 4
) (
  input  wire               clk,
  input  ffac_pkg::wq_cmd_t cmd,
  input  wire [IW-1:0]      idx,
  input  ffac_pkg::wq_ent_t hi,
  output ffac_pkg::wq_ent_t ent
);

  ffac_pkg::wq_ent_t ent_r, ent_nxt;
  int p;

  assign p   = int'(idx);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      ffac_pkg::WQ_WRITE: begin
        if (POS == p) ent_nxt = cmd.wdata;
      end
      ffac_pkg::WQ_REMOVE: begin
        if (POS >= p) ent_nxt = hi;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

### sv/first_fit_allocator_with_compaction_core.sv
// First-fit allocator with compaction.
// Input channel (in_valid/in_stall/in_data): an allocation request or a time tick.
// Result channel (out_valid/out_stall/out_data): placed, queued, freed or rejected
// events; out_data.last marks the final result of a transaction. A tick that
// frees and places nothing gives no result.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 memory size,
// index 1 OS size; either write empties the segment table and wait queue.
// One item is worked on at a time; in_stall stays high until its last result has
// been handed to the output register. A request scans the table for a first fit,
// then fills or splits that hole or appends at the top, compacting first if needed;
// a tick scans for segments that end at its time, frees them, then tries each
// waiter in queue order. The fit scan reads one cell per cycle. A result
// waits in a one-entry hold stage so that last can be set; the output register
// holds while out_stall is high and the sequencer waits behind it.
// Reset: memory size 4096, OS size 256, empty table and queue.
`default_nettype none
module first_fit_allocator_with_compaction_core #(
  parameter int MAX_SEGMENTS = 16,
  parameter int QUEUE_DEPTH  = 16
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  ffac_pkg::in_t   in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output ffac_pkg::out_t  out_data,
  input  wire             cfg_valid,
  output logic            cfg_ready,
  input  wire [1:0]       cfg_index,
  input  wire [15:0]      cfg_data
);

  localparam int SIW = $clog2(MAX_SEGMENTS);
  localparam int SCW = $clog2(MAX_SEGMENTS + 1);
  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_CMP_SCAN, S_REBASE, S_APPEND, S_PDONE,
    S_EMIT, S_FREE_SCAN, S_WAIT_LOAD, S_FINISH
  } state_t;

  typedef enum logic {CTX_REQ, CTX_WAIT} ctx_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  ctx_t   ctx_r, ctx_nxt;

  logic [SCW-1:0] i_r, i_nxt, seg_count_r, seg_count_nxt;
  logic [QCW-1:0] k_r, k_nxt, wait_count_r, wait_count_nxt;
  logic [15:0]    top_r, top_nxt, mem_r, mem_nxt, os_r, os_nxt;
  logic [15:0]    holes_r, holes_nxt, next_r, next_nxt;
  logic           fit_v_r, fit_v_nxt;
  logic [SIW-1:0] fit_idx_r, fit_idx_nxt;
  ffac_pkg::seg_ent_t fit_ent_r, fit_ent_nxt;
  logic [7:0]     p_proc_r, p_proc_nxt;
  logic [15:0]    p_size_r, p_size_nxt, p_end_r, p_end_nxt;
  ffac_pkg::in_t  req_r, req_nxt;
  logic           pok_r, pok_nxt;
  logic [15:0]    pbase_r, pbase_nxt;
  ffac_pkg::out_t em_r, em_nxt, hold_r, hold_nxt, out_r, out_nxt;
  logic           hold_v_r, hold_v_nxt, out_valid_r, out_valid_nxt;

  ffac_pkg::seg_cmd_t seg_cmd;
  logic [SIW-1:0]     seg_idx;
  ffac_pkg::wq_cmd_t  wq_cmd;
  logic [QIW-1:0]     wq_idx;

  ffac_pkg::seg_ent_t seg_q [MAX_SEGMENTS];
  ffac_pkg::wq_ent_t  wq_q  [QUEUE_DEPTH];
  ffac_pkg::seg_ent_t seg_rd;
  ffac_pkg::wq_ent_t  wq_rd;

  logic out_free, in_acc, cfg_wr, cfg_hit;
  logic [15:0] new_mem, new_os;

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_seg
      ffac_seg_cell #(.POS(g), .IW(SIW)) u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (seg_cmd),
        .idx  (seg_idx),
        .lo   (seg_q[(g == 0) ? 0 : g - 1]),
        .hi   (seg_q[(g == MAX_SEGMENTS - 1) ? g : g + 1]),
        .ent  (seg_q[g])
      );
    end
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_wq
      ffac_wait_cell #(.POS(g), .IW(QIW)) u_cell (
        .clk(clk),
        .cmd(wq_cmd),
        .idx(wq_idx),
        .hi (wq_q[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
        .ent(wq_q[g])
      );
    end
  endgenerate

  assign seg_rd    = seg_q[i_r[SIW-1:0]];
  assign wq_rd     = wq_q[k_r[QIW-1:0]];
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && (cfg_index == ffac_pkg::CFG_MEM_SIZE ||
                                cfg_index == ffac_pkg::CFG_OS_SIZE);
  assign new_mem   = (cfg_index == ffac_pkg::CFG_MEM_SIZE) ? cfg_data : mem_r;
  assign new_os    = (cfg_index == ffac_pkg::CFG_OS_SIZE) ? cfg_data : os_r;

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    ctx_nxt        = ctx_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    seg_count_nxt  = seg_count_r;
    wait_count_nxt = wait_count_r;
    top_nxt        = top_r;
    mem_nxt        = mem_r;
    os_nxt         = os_r;
    holes_nxt      = holes_r;
    next_nxt       = next_r;
    fit_v_nxt      = fit_v_r;
    fit_idx_nxt    = fit_idx_r;
    fit_ent_nxt    = fit_ent_r;
    p_proc_nxt     = p_proc_r;
    p_size_nxt     = p_size_r;
    p_end_nxt      = p_end_r;
    req_nxt        = req_r;
    pok_nxt        = pok_r;
    pbase_nxt      = pbase_r;
    em_nxt         = em_r;
    hold_nxt       = hold_r;
    hold_v_nxt     = hold_v_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    seg_cmd        = '0;
    seg_cmd.op     = ffac_pkg::SEG_NOP;
    seg_idx        = i_r[SIW-1:0];
    wq_cmd         = '0;
    wq_cmd.op      = ffac_pkg::WQ_NOP;
    wq_idx         = k_r[QIW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt    = in_data;
          p_proc_nxt = in_data.proc_id;
          p_size_nxt = in_data.req_size;
          p_end_nxt  = in_data.end_time;
          i_nxt      = '0;
          k_nxt      = '0;
          holes_nxt  = '0;
          fit_v_nxt  = 1'b0;
          ctx_nxt    = CTX_REQ;
          if (in_data.opcode == ffac_pkg::OP_TICK) begin
            state_nxt = S_FREE_SCAN;
          end else if (in_data.req_size == 16'd0) begin
            em_nxt    = '{ffac_pkg::EV_REJECTED, in_data.proc_id, 16'd0, 16'd0, 1'b0};
            ret_nxt   = S_FINISH;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (i_r < seg_count_r) begin
          if (!seg_rd.used) begin
            holes_nxt = holes_r + seg_rd.len;
            if (!fit_v_r && seg_rd.len >= p_size_r) begin
              fit_v_nxt   = 1'b1;
              fit_idx_nxt = i_r[SIW-1:0];
              fit_ent_nxt = seg_rd;
            end
          end
          i_nxt = i_r + 1'b1;
        end else begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        pok_nxt   = 1'b0;
        i_nxt     = '0;
        state_nxt = S_PDONE;
        if (fit_v_r) begin
          seg_idx            = fit_idx_r;
          seg_cmd.size       = p_size_r;
          seg_cmd.wdata      = '{1'b1, p_proc_r, fit_ent_r.base, fit_ent_r.len, p_end_r};
          pbase_nxt          = fit_ent_r.base;
          if (fit_ent_r.len == p_size_r) begin
            seg_cmd.op = ffac_pkg::SEG_WRITE;
            pok_nxt    = 1'b1;
          end else if (seg_count_r < SCW'(MAX_SEGMENTS)) begin
            seg_cmd.op    = ffac_pkg::SEG_SPLIT;
            seg_count_nxt = seg_count_r + 1'b1;
            pok_nxt       = 1'b1;
          end else begin
            state_nxt = S_CMP_SCAN;
          end
        end else if (top_r >= p_size_r) begin
          if (seg_count_r < SCW'(MAX_SEGMENTS)) state_nxt = S_APPEND;
          else if (holes_r != 16'd0)            state_nxt = S_CMP_SCAN;
        end else if ({1'b0, holes_r} + {1'b0, top_r} >= {1'b0, p_size_r}) begin
          state_nxt = S_CMP_SCAN;
        end
      end

      S_CMP_SCAN: begin
        if (i_r < seg_count_r) begin
          if (!seg_rd.used) begin
            seg_cmd.op    = ffac_pkg::SEG_REMOVE;
            seg_count_nxt = seg_count_r - 1'b1;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          i_nxt     = '0;
          next_nxt  = os_r;
          state_nxt = S_REBASE;
        end
      end

      S_REBASE: begin
        if (i_r < seg_count_r) begin
          seg_cmd.op         = ffac_pkg::SEG_SET_BASE;
          seg_cmd.wdata.base = next_r;
          next_nxt           = next_r + seg_rd.len;
          i_nxt              = i_r + 1'b1;
        end else begin
          top_nxt   = top_r + holes_r;
          state_nxt = S_APPEND;
        end
      end

      S_APPEND: begin
        seg_idx       = seg_count_r[SIW-1:0];
        seg_cmd.op    = ffac_pkg::SEG_WRITE;
        seg_cmd.wdata = '{1'b1, p_proc_r, mem_r - top_r, p_size_r, p_end_r};
        pbase_nxt     = mem_r - top_r;
        top_nxt       = top_r - p_size_r;
        seg_count_nxt = seg_count_r + 1'b1;
        pok_nxt       = 1'b1;
        state_nxt     = S_PDONE;
      end

      S_PDONE: begin
        state_nxt = S_EMIT;
        if (ctx_r == CTX_REQ) begin
          ret_nxt = S_FINISH;
          if (pok_r) begin
            em_nxt = '{ffac_pkg::EV_PLACED, p_proc_r, pbase_r, p_size_r, 1'b0};
          end else if (wait_count_r < QCW'(QUEUE_DEPTH)) begin
            wq_idx         = wait_count_r[QIW-1:0];
            wq_cmd.op      = ffac_pkg::WQ_WRITE;
            wq_cmd.wdata   = '{p_proc_r, p_size_r, req_r.end_time - req_r.time_value};
            wait_count_nxt = wait_count_r + 1'b1;
            em_nxt = '{ffac_pkg::EV_QUEUED, p_proc_r, 16'd0, p_size_r, 1'b0};
          end else begin
            em_nxt = '{ffac_pkg::EV_REJECTED, p_proc_r, 16'd0, p_size_r, 1'b0};
          end
        end else if (pok_r) begin
          em_nxt         = '{ffac_pkg::EV_PLACED, p_proc_r, pbase_r, p_size_r, 1'b0};
          wq_cmd.op      = ffac_pkg::WQ_REMOVE;
          wait_count_nxt = wait_count_r - 1'b1;
          ret_nxt        = S_WAIT_LOAD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_WAIT_LOAD;
        end
      end

      S_EMIT: begin
        if (!hold_v_r) begin
          hold_nxt   = em_r;
          hold_v_nxt = 1'b1;
          state_nxt  = ret_r;
        end else if (out_free) begin
          out_nxt       = hold_r;
          out_valid_nxt = 1'b1;
          hold_nxt      = em_r;
          state_nxt     = ret_r;
        end
      end

      S_FREE_SCAN: begin
        if (i_r < seg_count_r) begin
          i_nxt = i_r + 1'b1;
          if (seg_rd.used && seg_rd.fin_time == req_r.time_value) begin
            seg_cmd.op = ffac_pkg::SEG_CLR_USED;
            em_nxt = '{ffac_pkg::EV_FREED, seg_rd.owner, seg_rd.base, seg_rd.len, 1'b0};
            ret_nxt    = S_FREE_SCAN;
            state_nxt  = S_EMIT;
          end
        end else begin
          state_nxt = S_WAIT_LOAD;
        end
      end

      S_WAIT_LOAD: begin
        if (k_r < wait_count_r) begin
          ctx_nxt    = CTX_WAIT;
          p_proc_nxt = wq_rd.owner;
          p_size_nxt = wq_rd.len;
          p_end_nxt  = req_r.time_value + wq_rd.dur;
          i_nxt      = '0;
          holes_nxt  = '0;
          fit_v_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt       = hold_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          hold_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (cfg_hit) begin
      mem_nxt        = new_mem;
      os_nxt         = new_os;
      top_nxt        = (new_mem >= new_os) ? new_mem - new_os : 16'd0;
      seg_count_nxt  = '0;
      wait_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      ctx_r        <= CTX_REQ;
      seg_count_r  <= '0;
      wait_count_r <= '0;
      mem_r        <= 16'd4096;
      os_r         <= 16'd256;
      top_r        <= 16'd3840;
      hold_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      ctx_r        <= ctx_nxt;
      seg_count_r  <= seg_count_nxt;
      wait_count_r <= wait_count_nxt;
      mem_r        <= mem_nxt;
      os_r         <= os_nxt;
      top_r        <= top_nxt;
      hold_v_r     <= hold_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    holes_r   <= holes_nxt;
    next_r    <= next_nxt;
    fit_v_r   <= fit_v_nxt;
    fit_idx_r <= fit_idx_nxt;
    fit_ent_r <= fit_ent_nxt;
    p_proc_r  <= p_proc_nxt;
    p_size_r  <= p_size_nxt;
    p_end_r   <= p_end_nxt;
    req_r     <= req_nxt;
    pok_r     <= pok_nxt;
    pbase_r   <= pbase_nxt;
    em_r      <= em_nxt;
    hold_r    <= hold_nxt;
    out_r     <= out_nxt;
  end

  a_seg_count: assert property (@(posedge clk) disable iff (!rst_n)
    seg_count_r <= SCW'(MAX_SEGMENTS))
    else $error("segment count beyond table size");

  a_wait_count: assert property (@(posedge clk) disable iff (!rst_n)
    wait_count_r <= QCW'(QUEUE_DEPTH))
    else $error("wait count beyond queue depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_v_r)
    else $error("result left in hold stage at idle");

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.opcode == ffac_pkg::OP_ALLOC) |=> (state_r != S_IDLE))
    else $error("request accepted without producing a result");

endmodule
`default_nettype wire
